// ===== hw/rtl/pcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmc_pkg: shared types and constants for the median centroid unit
// Sizes of the point store, the request and result structs and the
// controller state encoding.
// ----------------------------------------------------------------------------
package pcmc_pkg;

  // Store depth and coordinate width
  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CntW      = $clog2(MaxPoints + 1);

  // Sign bit of a coordinate; flipping it turns signed order into unsigned
  localparam logic [CoordW-1:0] SignBit = {1'b1, {(CoordW - 1){1'b0}}};

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic                     batch_end;
  } pcmc_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic signed [CoordW-1:0] centroid_z;
    logic        [CntW-1:0]   points_held;
    logic                     overflowed;
  } pcmc_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StLast,
    StDecide,
    StDone
  } pcmc_state_e;

endpackage

// ===== hw/rtl/point_cloud_median_centroid_unit.sv =====
// ----------------------------------------------------------------------------
// point_cloud_median_centroid_unit: per-axis median of a growing point store
// Appends each point to a cumulative store until it is full and, on a batch
// end, finds the median of every axis by a bit-serial radix select over the store.
// ----------------------------------------------------------------------------
//
//  channel   | signals                          | direction
//  ----------+----------------------------------+----------
//  point     | in_valid_i, in_ready_o, in_data_i | in
//  centroid  | out_valid_o, out_ready_i, out_data_o | out
//
//  Points are accepted only in the idle state. On a batch end, each median
//  bit needs one full pass over the store through the single read port of
//  each axis memory, then one state to drain the read register and one to
//  decide; the finished search then passes through the done state.
//  The store needs no clearing after reset; rst_ni clears count and flags.
//  A waiting centroid does not block new points; a finished search waits
//  in the done state until the output register is free.
//
module point_cloud_median_centroid_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcmc_pkg::pcmc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcmc_pkg::pcmc_out_t out_data_o
);

  localparam int unsigned CoordW = pcmc_pkg::CoordW;
  localparam int unsigned CntW   = pcmc_pkg::CntW;
  localparam int unsigned AddrW  = pcmc_pkg::AddrW;

  pcmc_pkg::pcmc_state_e state_q, state_d;

  logic [CntW-1:0]   count_q;
  logic              ovf_q;
  logic [CntW-1:0]   scan_idx_q;
  logic              rd_v_q;
  logic [CoordW-1:0] hi_mask_q;
  logic [CoordW-1:0] bit_mask_q;
  logic [2:0][CoordW-1:0] prefix_q;
  logic [2:0][CntW-1:0]   rank_q;
  logic [2:0][CntW-1:0]   zeros_q;
  logic [2:0][CoordW-1:0] rd_q;

  logic              out_valid_q;
  pcmc_pkg::pcmc_out_t out_q;

  // Point stores, one per axis
  logic [CoordW-1:0] mem_x [pcmc_pkg::MaxPoints];
  logic [CoordW-1:0] mem_y [pcmc_pkg::MaxPoints];
  logic [CoordW-1:0] mem_z [pcmc_pkg::MaxPoints];

  logic            in_fire;
  logic            store_full;
  logic            wr_en;
  logic [CntW-1:0] count_new;
  logic            scan_end;
  logic            rd_en;
  logic            start;
  logic            load_out;

  assign in_fire    = in_valid_i && in_ready_o;
  assign store_full = (count_q == CntW'(pcmc_pkg::MaxPoints));
  assign wr_en      = in_fire && !store_full;
  assign count_new  = store_full ? count_q : count_q + CntW'(1);
  assign scan_end   = (scan_idx_q == count_q - CntW'(1));
  assign start      = in_fire && in_data_i.batch_end;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcmc_pkg::StIdle: begin
        if (start) state_d = pcmc_pkg::StScan;
      end
      pcmc_pkg::StScan: begin
        if (scan_end) state_d = pcmc_pkg::StLast;
      end
      pcmc_pkg::StLast: begin
        state_d = pcmc_pkg::StDecide;
      end
      pcmc_pkg::StDecide: begin
        state_d = bit_mask_q[0] ? pcmc_pkg::StDone : pcmc_pkg::StScan;
      end
      pcmc_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) state_d = pcmc_pkg::StIdle;
      end
      default: state_d = pcmc_pkg::StIdle;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      pcmc_pkg::StIdle:   in_ready_o = 1'b1;
      pcmc_pkg::StScan:   rd_en      = 1'b1;
      pcmc_pkg::StLast:   ;
      pcmc_pkg::StDecide: ;
      pcmc_pkg::StDone:   load_out   = !out_valid_q || out_ready_i;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pcmc_pkg::StIdle;
    else         state_q <= state_d;
  end

  // Store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[count_q[AddrW-1:0]] <= in_data_i.point_x;
      mem_y[count_q[AddrW-1:0]] <= in_data_i.point_y;
      mem_z[count_q[AddrW-1:0]] <= in_data_i.point_z;
    end
    if (rd_en) begin
      rd_q[0] <= mem_x[scan_idx_q[AddrW-1:0]];
      rd_q[1] <= mem_y[scan_idx_q[AddrW-1:0]];
      rd_q[2] <= mem_z[scan_idx_q[AddrW-1:0]];
    end
  end

  // Track fill level and dropped points
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_fire) begin
      count_q <= count_new;
      if (store_full) ovf_q <= 1'b1;
    end
  end

  // Advance the scan address and the read-valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_v_q     <= 1'b0;
    end else begin
      rd_v_q <= rd_en;
      if (rd_en) scan_idx_q <= scan_idx_q + CntW'(1);
      else       scan_idx_q <= '0;
    end
  end

  // Radix select: one median bit per pass, MSB first, per axis
  always_ff @(posedge clk_i) begin
    if (start) begin
      hi_mask_q  <= '0;
      bit_mask_q <= pcmc_pkg::SignBit;
      for (int a = 0; a < 3; a++) begin
        prefix_q[a] <= '0;
        rank_q[a]   <= count_new >> 1;
        zeros_q[a]  <= '0;
      end
    end else if (state_q == pcmc_pkg::StDecide) begin
      hi_mask_q  <= hi_mask_q | bit_mask_q;
      bit_mask_q <= bit_mask_q >> 1;
      for (int a = 0; a < 3; a++) begin
        zeros_q[a] <= '0;
        if (rank_q[a] >= zeros_q[a]) begin
          prefix_q[a] <= prefix_q[a] | bit_mask_q;
          rank_q[a]   <= rank_q[a] - zeros_q[a];
        end
      end
    end else if (rd_v_q) begin
      // count candidates whose current bit is zero
      for (int a = 0; a < 3; a++) begin
        if ((((rd_q[a] ^ pcmc_pkg::SignBit ^ prefix_q[a]) & hi_mask_q) == '0) &&
            (((rd_q[a] ^ pcmc_pkg::SignBit) & bit_mask_q) == '0)) begin
          zeros_q[a] <= zeros_q[a] + CntW'(1);
        end
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.centroid_x  <= prefix_q[0] ^ pcmc_pkg::SignBit;
      out_q.centroid_y  <= prefix_q[1] ^ pcmc_pkg::SignBit;
      out_q.centroid_z  <= prefix_q[2] ^ pcmc_pkg::SignBit;
      out_q.points_held <= count_q;
      out_q.overflowed  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/pcmc_checker.sv =====
// ----------------------------------------------------------------------------
// pcmc_checker: port-level checks for the median centroid unit
// Watches the point and centroid channels and flags illegal results.
// ----------------------------------------------------------------------------
module pcmc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input pcmc_pkg::pcmc_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input pcmc_pkg::pcmc_out_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("centroid changed while stalled");

  // A result always covers at least one point and never more than the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.points_held != '0 &&
                     out_data_o.points_held <= pcmc_pkg::CntW'(pcmc_pkg::MaxPoints)))
    else $error("points_held out of range");

  // Drop points only once the store is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflowed) |->
      (out_data_o.points_held == pcmc_pkg::CntW'(pcmc_pkg::MaxPoints)))
    else $error("overflow flagged below capacity");

  // A batch end starts the search and stalls the point channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.batch_end) |=> !in_ready_o)
    else $error("point accepted during median search");

endmodule

bind point_cloud_median_centroid_unit pcmc_checker u_pcmc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
